[hw/rtl/pips_pkg.sv]
// ----------------------------------------------------------------------------
// pips_pkg
// Shared types, codes and the step decoder of the point-in-primitive filter.
// ----------------------------------------------------------------------------
package pips_pkg;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         shape_index;
    logic [4:0]         word_index;
    logic signed [31:0] word_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               point_finite;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic        keep_point;
    logic [19:0] kept_count;
    logic        cloud_done;
  } out_item_t;

  localparam logic CMD_TEST  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [1:0] SHAPE_BOX      = 2'd0;
  localparam logic [1:0] SHAPE_SPHERE   = 2'd1;
  localparam logic [1:0] SHAPE_CYLINDER = 2'd2;

  localparam logic [4:0] WORD_TYPE   = 5'd0;
  localparam logic [4:0] WORD_ACTIVE = 5'd1;
  localparam logic [4:0] WORD_RADIUS = 5'd20;
  localparam logic [4:0] WORD_LAST   = 5'd20;

  localparam logic [5:0] STEP_ISSUE_END = 6'd31;
  localparam logic [5:0] STEP_LAST      = 6'd33;

  localparam logic [3:0] OP_NOP  = 4'd0;
  localparam logic [3:0] OP_ACT  = 4'd1;
  localparam logic [3:0] OP_TYPE = 4'd2;
  localparam logic [3:0] OP_RAD  = 4'd3;
  localparam logic [3:0] OP_CEN  = 4'd4;
  localparam logic [3:0] OP_ROT  = 4'd5;
  localparam logic [3:0] OP_TRN  = 4'd6;
  localparam logic [3:0] OP_EXT  = 4'd7;
  localparam logic [3:0] OP_ESQ  = 4'd8;
  localparam logic [3:0] OP_QSQ  = 4'd9;

  localparam logic [1:0] SH_NONE = 2'd0;
  localparam logic [1:0] SH_2F   = 2'd1;
  localparam logic [1:0] SH_33   = 2'd2;
  localparam logic [1:0] SH_64   = 2'd3;

  localparam logic [2:0] DST_NONE = 3'd0;
  localparam logic [2:0] DST_D2   = 3'd1;
  localparam logic [2:0] DST_R2   = 3'd2;
  localparam logic [2:0] DST_Q    = 3'd3;
  localparam logic [2:0] DST_E2   = 3'd4;
  localparam logic [2:0] DST_S01  = 3'd5;
  localparam logic [2:0] DST_S2   = 3'd6;

  typedef struct packed {
    logic [3:0] op;
    logic [4:0] word;
    logic [1:0] idx;
    logic [1:0] sub;
  } micro_t;

  localparam micro_t MICRO_NOP = '{op: OP_NOP, word: WORD_TYPE, idx: 2'd0, sub: 2'd0};

  typedef struct packed {
    logic issue;
    logic clr_acc;
    logic clr_we;
    logic wr_word;
    logic load_pt;
    logic finish;
    logic hit;
  } ctl_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_busy;
  } ctl_status_t;

  function automatic micro_t step_decode(input logic [5:0] step);
    micro_t m;
    m = MICRO_NOP;
    if (step == 6'd0) begin
      m.op = OP_ACT;
      m.word = WORD_ACTIVE;
    end else if (step == 6'd1) begin
      m.op = OP_RAD;
      m.word = WORD_RADIUS;
    end else if (step inside {[6'd2:6'd4]}) begin
      m.op = OP_CEN;
      m.word = 5'(step);
      m.idx = 2'(step - 6'd2);
    end else if (step == 6'd5) begin
      m.op = OP_TYPE;
      m.word = WORD_TYPE;
    end else if (step inside {[6'd6:6'd8]}) begin
      m.op = OP_ROT;
      m.word = 5'(step - 6'd1);
      m.idx = 2'd0;
      m.sub = 2'(step - 6'd6);
    end else if (step inside {[6'd9:6'd11]}) begin
      m.op = OP_ROT;
      m.word = 5'(step - 6'd1);
      m.idx = 2'd1;
      m.sub = 2'(step - 6'd9);
    end else if (step inside {[6'd12:6'd14]}) begin
      m.op = OP_ROT;
      m.word = 5'(step - 6'd1);
      m.idx = 2'd2;
      m.sub = 2'(step - 6'd12);
    end else if (step inside {[6'd15:6'd17]}) begin
      m.op = OP_TRN;
      m.word = 5'(step - 6'd1);
      m.idx = 2'(step - 6'd15);
    end else if (step inside {[6'd18:6'd20]}) begin
      m.op = OP_EXT;
      m.word = 5'(step - 6'd1);
      m.idx = 2'(step - 6'd18);
    end else if (step == 6'd21) begin
      m.op = OP_ESQ;
    end else if (step inside {[6'd22:6'd24]}) begin
      m.op = OP_QSQ;
      m.idx = 2'd0;
      m.sub = 2'(step - 6'd22);
    end else if (step inside {[6'd25:6'd27]}) begin
      m.op = OP_QSQ;
      m.idx = 2'd1;
      m.sub = 2'(step - 6'd25);
    end else if (step inside {[6'd28:6'd30]}) begin
      m.op = OP_QSQ;
      m.idx = 2'd2;
      m.sub = 2'(step - 6'd28);
    end
    return m;
  endfunction

endpackage

[hw/rtl/pips_ram.sv]
// ----------------------------------------------------------------------------
// pips_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module pips_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/pips_ctrl.sv]
// ----------------------------------------------------------------------------
// pips_ctrl
// Sequencer: table clearing, input handshake, shape walk and result hand-off.
// ----------------------------------------------------------------------------
module pips_ctrl
  import pips_pkg::*;
#(
  parameter int NUM_SHAPES = 64,
  localparam int SW = (NUM_SHAPES > 1) ? $clog2(NUM_SHAPES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_wdata,
  input  logic          in_valid,
  input  logic          in_cmd,
  input  logic          in_finite,
  output logic          in_ready,
  input  ctl_status_t   st,
  output ctl_cmd_t      cmd,
  output logic [SW-1:0] shape,
  output logic [5:0]    step
);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [SW-1:0] shape_r, shape_nxt;
  logic [5:0]    step_r, step_nxt;
  logic          hit_r, hit_nxt;
  logic [6:0]    siu_r;
  logic [10:0]   n_lim;

  assign n_lim = (11'(siu_r) > 11'(NUM_SHAPES)) ? 11'(NUM_SHAPES) : 11'(siu_r);
  assign shape = shape_r;
  assign step  = step_r;

  always_comb begin
    state_nxt = state_r;
    shape_nxt = shape_r;
    step_nxt  = step_r;
    hit_nxt   = hit_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_CLR: begin
        cmd.clr_we = 1'b1;
        if (11'(shape_r) == 11'(NUM_SHAPES - 1)) begin
          state_nxt = ST_IDLE;
          shape_nxt = '0;
        end else begin
          shape_nxt = shape_r + SW'(1);
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_WRITE) begin
            cmd.wr_word = 1'b1;
          end else begin
            cmd.load_pt = 1'b1;
            hit_nxt = 1'b0;
            if (!in_finite || n_lim == 11'd0) begin
              state_nxt = ST_FIN;
            end else begin
              state_nxt = ST_RUN;
              shape_nxt = '0;
              step_nxt = '0;
            end
          end
        end
      end
      ST_RUN: begin
        cmd.issue   = (step_r < STEP_ISSUE_END);
        cmd.clr_acc = (step_r == 6'd0);
        if (step_r == STEP_LAST) begin
          step_nxt = '0;
          if (st.hit) begin
            hit_nxt = 1'b1;
            state_nxt = ST_FIN;
          end else if (11'(shape_r) + 11'd1 == n_lim) begin
            state_nxt = ST_FIN;
          end else begin
            shape_nxt = shape_r + SW'(1);
          end
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ST_FIN: begin
        cmd.hit = hit_r;
        if (!st.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      shape_r <= '0;
      step_r  <= '0;
      hit_r   <= 1'b0;
      siu_r   <= '0;
    end else begin
      state_r <= state_nxt;
      shape_r <= shape_nxt;
      step_r  <= step_nxt;
      hit_r   <= hit_nxt;
      if (cfg_we) begin
        siu_r <= cfg_wdata;
      end
    end
  end

  a_run_shape_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (11'(shape_r) < n_lim))
    else $error("shape walk ran past the shapes in use");

  a_test_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd == CMD_TEST && in_finite && n_lim != 11'd0)
    |=> (state_r == ST_RUN && step_r == 6'd0 && shape_r == '0))
    else $error("test transaction did not start a shape walk");

  a_finish_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> in_ready)
    else $error("input not ready after a result was handed off");

endmodule

[hw/rtl/pips_dpath.sv]
// ----------------------------------------------------------------------------
// pips_dpath
// Shape table, shared multiply-accumulate pipeline, containment tests, counter.
// ----------------------------------------------------------------------------
module pips_dpath
  import pips_pkg::*;
#(
  parameter int NUM_SHAPES = 64,
  parameter int FRAC_BITS  = 16,
  parameter int COUNT_BITS = 20,
  localparam int SW = (NUM_SHAPES > 1) ? $clog2(NUM_SHAPES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  in_item_t      in_data,
  input  ctl_cmd_t      cmd,
  input  logic [SW-1:0] shape,
  input  logic [5:0]    step,
  output ctl_status_t   st,
  output logic          out_valid,
  input  logic          out_ready,
  output out_item_t     out_data
);

  localparam int ACC_W = 132;
  localparam int QW    = 67;
  localparam int D2W   = 68;
  localparam int R2W   = 64;
  localparam int E2W   = 64 + 2 * FRAC_BITS;
  localparam int SQW   = 132;
  localparam int AW    = SW + 5;
  localparam logic signed [32:0] ONE_Q = 33'sd1 <<< FRAC_BITS;

  // Shape table.
  logic [10:0]    wsh;
  logic           wr_ok, ram_we;
  logic [AW-1:0]  waddr, raddr;
  logic [31:0]    wdata, rdata;
  micro_t         mi;

  assign wsh   = 11'(in_data.shape_index);
  assign wr_ok = cmd.wr_word && (wsh < 11'(NUM_SHAPES)) && (in_data.word_index <= WORD_LAST);
  assign ram_we = cmd.clr_we || wr_ok;
  assign waddr = cmd.clr_we ? {shape, WORD_ACTIVE} : {wsh[SW-1:0], in_data.word_index};
  assign wdata = cmd.clr_we ? 32'd0 : in_data.word_value;
  assign mi    = step_decode(step);
  assign raddr = {shape, mi.word};

  pips_ram #(.WIDTH(32), .DEPTH(32 << SW)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Point and per-shape registers.
  logic signed [31:0] px_r, py_r, pz_r;
  logic               last_r;
  micro_t             tag0_r;
  logic               act_r;
  logic [1:0]         type_r;
  logic signed [31:0] ext_r [3];

  // Accumulators.
  logic [D2W-1:0]        d2_r;
  logic [R2W-1:0]        r2_r;
  logic [E2W-1:0]        e2_r;
  logic [SQW-1:0]        s01_r, s2_r;
  logic signed [QW-1:0]  q_r [3];
  logic [63:0]           qmag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qmag[i] = q_r[i][QW-1] ? 64'(-q_r[i]) : 64'(q_r[i]);
    end
  end

  // Multiply stage.
  logic signed [31:0] d, p_idx, p_sub;
  logic signed [32:0] a, b, diff;
  logic [63:0]        m_sel;
  logic [1:0]         sh_nxt, sh_r;
  logic [2:0]         dst_nxt, dst_r;
  logic [1:0]         qi_r;
  logic signed [65:0] prod_nxt, prod_r;

  assign d = signed'(rdata);

  always_comb begin
    case (tag0_r.idx)
      2'd0:    p_idx = px_r;
      2'd1:    p_idx = py_r;
      default: p_idx = pz_r;
    endcase
    case (tag0_r.sub)
      2'd0:    p_sub = px_r;
      2'd1:    p_sub = py_r;
      default: p_sub = pz_r;
    endcase
    case (tag0_r.idx)
      2'd0:    m_sel = qmag[0];
      2'd1:    m_sel = qmag[1];
      default: m_sel = qmag[2];
    endcase
    diff    = 33'(p_idx) - 33'(d);
    a       = '0;
    b       = '0;
    sh_nxt  = SH_NONE;
    dst_nxt = DST_NONE;
    case (tag0_r.op)
      OP_RAD: begin
        a = 33'(d);
        b = 33'(d);
        dst_nxt = DST_R2;
      end
      OP_CEN: begin
        a = diff;
        b = diff;
        dst_nxt = DST_D2;
      end
      OP_ROT: begin
        a = 33'(d);
        b = 33'(p_sub);
        dst_nxt = DST_Q;
      end
      OP_TRN: begin
        a = 33'(d);
        b = ONE_Q;
        dst_nxt = DST_Q;
      end
      OP_ESQ: begin
        a = 33'(ext_r[0]);
        b = 33'(ext_r[0]);
        sh_nxt = SH_2F;
        dst_nxt = DST_E2;
      end
      OP_QSQ: begin
        dst_nxt = (tag0_r.idx == 2'd2) ? DST_S2 : DST_S01;
        case (tag0_r.sub)
          2'd0: begin
            a = {1'b0, m_sel[31:0]};
            b = {1'b0, m_sel[31:0]};
          end
          2'd1: begin
            a = {1'b0, m_sel[63:32]};
            b = {1'b0, m_sel[31:0]};
            sh_nxt = SH_33;
          end
          default: begin
            a = {1'b0, m_sel[63:32]};
            b = {1'b0, m_sel[63:32]};
            sh_nxt = SH_64;
          end
        endcase
      end
      default: begin
        dst_nxt = DST_NONE;
      end
    endcase
    prod_nxt = a * b;
  end

  // Accumulate stage.
  logic signed [ACC_W-1:0] addend, addend_sh, base, sum;

  always_comb begin
    addend = ACC_W'(prod_r);
    case (sh_r)
      SH_2F:   addend_sh = addend <<< (2 * FRAC_BITS);
      SH_33:   addend_sh = addend <<< 33;
      SH_64:   addend_sh = addend <<< 64;
      default: addend_sh = addend;
    endcase
    case (dst_r)
      DST_D2:  base = ACC_W'(d2_r);
      DST_R2:  base = ACC_W'(r2_r);
      DST_E2:  base = ACC_W'(e2_r);
      DST_S01: base = ACC_W'(s01_r);
      DST_S2:  base = ACC_W'(s2_r);
      DST_Q: begin
        case (qi_r)
          2'd0:    base = ACC_W'(q_r[0]);
          2'd1:    base = ACC_W'(q_r[1]);
          default: base = ACC_W'(q_r[2]);
        endcase
      end
      default: base = '0;
    endcase
    sum = base + addend_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r <= MICRO_NOP;
      dst_r  <= DST_NONE;
    end else begin
      tag0_r <= cmd.issue ? mi : MICRO_NOP;
      dst_r  <= dst_nxt;
    end
    sh_r   <= sh_nxt;
    qi_r   <= tag0_r.idx;
    prod_r <= prod_nxt;
    case (tag0_r.op)
      OP_ACT:  act_r <= d[0];
      OP_TYPE: type_r <= d[1:0];
      OP_EXT: begin
        case (tag0_r.idx)
          2'd0:    ext_r[0] <= d;
          2'd1:    ext_r[1] <= d;
          default: ext_r[2] <= d;
        endcase
      end
      default: begin
      end
    endcase
    if (cmd.load_pt) begin
      px_r   <= in_data.point_x;
      py_r   <= in_data.point_y;
      pz_r   <= in_data.point_z;
      last_r <= in_data.last_point;
    end
    if (cmd.clr_acc) begin
      d2_r  <= '0;
      r2_r  <= '0;
      e2_r  <= '0;
      s01_r <= '0;
      s2_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        q_r[i] <= '0;
      end
    end else begin
      case (dst_r)
        DST_D2:  d2_r  <= sum[D2W-1:0];
        DST_R2:  r2_r  <= sum[R2W-1:0];
        DST_E2:  e2_r  <= sum[E2W-1:0];
        DST_S01: s01_r <= sum[SQW-1:0];
        DST_S2:  s2_r  <= sum[SQW-1:0];
        DST_Q: begin
          case (qi_r)
            2'd0:    q_r[0] <= sum[QW-1:0];
            2'd1:    q_r[1] <= sum[QW-1:0];
            default: q_r[2] <= sum[QW-1:0];
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Containment tests.
  logic [2:0]     box_ok;
  logic [63:0]    lim [3];
  logic [SQW:0]   sph_sum;
  logic           in_bound, sph_ok, cyl_ok, type_ok;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim[i]    = 64'(ext_r[i][30:0]) << FRAC_BITS;
      box_ok[i] = !ext_r[i][31] && (qmag[i] <= lim[i]);
    end
    in_bound = d2_r <= D2W'(r2_r);
    sph_sum  = (SQW + 1)'(s01_r) + (SQW + 1)'(s2_r);
    sph_ok   = sph_sum <= (SQW + 1)'(e2_r);
    cyl_ok   = box_ok[2] && (s01_r <= SQW'(e2_r));
    case (type_r)
      SHAPE_BOX:      type_ok = &box_ok;
      SHAPE_SPHERE:   type_ok = sph_ok;
      SHAPE_CYLINDER: type_ok = cyl_ok;
      default:        type_ok = 1'b0;
    endcase
  end

  assign st.hit = act_r && in_bound && type_ok;

  // Counter and output register.
  logic [COUNT_BITS-1:0] cnt_r, cnt_inc;
  logic [31:0]           cnt_wide;
  logic                  out_valid_r;
  out_item_t             out_r;

  assign cnt_inc     = cmd.hit ? cnt_r : cnt_r + COUNT_BITS'(1);
  assign cnt_wide    = 32'(cnt_inc);
  assign st.out_busy = out_valid_r && !out_ready;
  assign out_valid   = out_valid_r;
  assign out_data    = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        cnt_r <= last_r ? '0 : cnt_inc;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.finish) begin
      out_r.keep_point <= !cmd.hit;
      out_r.kept_count <= cnt_wide[19:0];
      out_r.cloud_done <= last_r;
    end
  end

  a_finish_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished transaction did not reach the output register");

endmodule

[hw/rtl/point_in_primitive_self_filter_unit.sv]
// ----------------------------------------------------------------------------
// point_in_primitive_self_filter_unit
// Tests points against a table of boxes, spheres and cylinders.
// ----------------------------------------------------------------------------
// A test transaction walks the shapes in use up to and including the first hit before it gives
// its result; one table entry is read per cycle and every product goes through the single
// shared multiplier, 34 steps per shape.
// One test is in work at a time; the input is ready again in the same cycle that its result appears on the output.
// After reset a clearing pass writes the active word of every shape to zero, marking all shapes inactive.
module point_in_primitive_self_filter_unit
  import pips_pkg::*;
#(
  parameter int NUM_SHAPES = 64,
  parameter int FRAC_BITS  = 16,
  parameter int COUNT_BITS = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [6:0] cfg_wdata,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int SW = (NUM_SHAPES > 1) ? $clog2(NUM_SHAPES) : 1;

  ctl_cmd_t      cmd;
  ctl_status_t   st;
  logic [SW-1:0] shape;
  logic [5:0]    step;

  pips_ctrl #(.NUM_SHAPES(NUM_SHAPES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_finite (in_data.point_finite),
    .in_ready  (in_ready),
    .st        (st),
    .cmd       (cmd),
    .shape     (shape),
    .step      (step)
  );

  pips_dpath #(
    .NUM_SHAPES (NUM_SHAPES),
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .shape     (shape),
    .step      (step),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[tb/sv/tb_point_in_primitive_self_filter_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_in_primitive_self_filter_unit
// Loads the shape table, sweeps the shapes-in-use register across several
// settings and sends directed and random point tests. Each result is compared
// against a fixed value or an exact wide-integer containment predictor.
// ----------------------------------------------------------------------------
module tb_point_in_primitive_self_filter_unit;
  import pips_pkg::*;

  localparam int ONE = 65536;
  localparam int CYCLE_LIMIT = 8000000;

  typedef logic signed [199:0] big_t;

  typedef struct {
    in_item_t  item;
    int        new_use;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic [6:0] cfg_wdata;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  logic [1:0]         tbl_type[64];
  logic               tbl_active[64];
  logic signed [31:0] tbl_center[64][3];
  logic signed [31:0] tbl_rot[64][9];
  logic signed [31:0] tbl_trans[64][3];
  logic signed [31:0] tbl_extent[64][3];
  logic signed [31:0] tbl_bound[64];
  logic [19:0]        kept_tally;
  int                 in_use;

  out_item_t pending_results[$];
  dir_row_t  dir_rows[$];
  int        mismatches;
  int        cycles;
  bit        send_burst;
  bit        recv_burst;

  point_in_primitive_self_filter_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  function automatic int slot_of(int k);
    return (k < 6) ? k : k + 56;
  endfunction

  function automatic bit axis_ok(big_t m, logic signed [31:0] half);
    big_t h;
    h = half;
    if (h < 0) return 1'b0;
    return m <= (h <<< 16);
  endfunction

  function automatic bit shape_contains(int s, logic signed [31:0] px,
                                        logic signed [31:0] py, logic signed [31:0] pz);
    big_t pv[3];
    big_t q[3];
    big_t d2, lim, tmp, acc, q2;
    pv[0] = px;
    pv[1] = py;
    pv[2] = pz;
    d2 = 0;
    for (int i = 0; i < 3; i++) begin
      tmp = tbl_center[s][i];
      tmp = pv[i] - tmp;
      d2 += tmp * tmp;
    end
    lim = tbl_bound[s];
    lim = lim * lim;
    if (d2 > lim) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = tbl_trans[s][i];
      acc = acc <<< 16;
      for (int j = 0; j < 3; j++) begin
        tmp = tbl_rot[s][i * 3 + j];
        acc += tmp * pv[j];
      end
      q[i] = (acc < 0) ? -acc : acc;
    end
    lim = tbl_extent[s][0];
    lim = (lim * lim) <<< 32;
    case (tbl_type[s])
      SHAPE_BOX: begin
        return axis_ok(q[0], tbl_extent[s][0]) && axis_ok(q[1], tbl_extent[s][1]) &&
               axis_ok(q[2], tbl_extent[s][2]);
      end
      SHAPE_SPHERE: begin
        q2 = q[0] * q[0] + q[1] * q[1] + q[2] * q[2];
        return q2 <= lim;
      end
      SHAPE_CYLINDER: begin
        if (!axis_ok(q[2], tbl_extent[s][2])) return 1'b0;
        q2 = q[0] * q[0] + q[1] * q[1];
        return q2 <= lim;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic filter_step(input in_item_t it, output bit has, output out_item_t r);
    int s;
    int w;
    bit inside_hit;
    has = 1'b0;
    r = '0;
    if (it.cmd == CMD_WRITE) begin
      s = it.shape_index;
      w = it.word_index;
      if (w == WORD_TYPE) tbl_type[s] = it.word_value[1:0];
      else if (w == WORD_ACTIVE) tbl_active[s] = it.word_value[0];
      else if (w <= 4) tbl_center[s][w - 2] = it.word_value;
      else if (w <= 13) tbl_rot[s][w - 5] = it.word_value;
      else if (w <= 16) tbl_trans[s][w - 14] = it.word_value;
      else if (w <= 19) tbl_extent[s][w - 17] = it.word_value;
      else if (w == WORD_RADIUS) tbl_bound[s] = it.word_value;
    end else begin
      inside_hit = 1'b0;
      if (it.point_finite) begin
        for (s = 0; s < ((in_use > 64) ? 64 : in_use) && !inside_hit; s++) begin
          if (tbl_active[s] && shape_contains(s, it.point_x, it.point_y, it.point_z))
            inside_hit = 1'b1;
        end
      end
      if (!inside_hit) kept_tally = kept_tally + 20'd1;
      r.keep_point = !inside_hit;
      r.kept_count = kept_tally;
      r.cloud_done = it.last_point;
      if (it.last_point) kept_tally = '0;
      has = 1'b1;
    end
  endtask

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    bit has;
    out_item_t r;
    if ($urandom_range(0, 59) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    filter_step(it, has, r);
    if (has) pending_results.insert(pending_results.size(), typed ? want : r);
  endtask

  task automatic write_word(input int s, input int w, input logic signed [31:0] v);
    in_item_t it;
    it = '0;
    it.cmd = CMD_WRITE;
    it.shape_index = 6'(s);
    it.word_index = 5'(w);
    it.word_value = v;
    it.point_x = $urandom;
    it.point_y = $urandom;
    it.point_z = $urandom;
    send_item(it, 1'b0, '0);
  endtask

  task automatic set_in_use(input int v);
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= 7'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    in_use = v & 127;
  endtask

  task automatic load_shape(input int s, input logic [1:0] kind, input bit act,
                            input logic signed [31:0] c[3], input logic signed [31:0] rt[9],
                            input logic signed [31:0] e[3], input logic signed [31:0] bound);
    longint acc;
    logic signed [31:0] upper;
    upper = $urandom;
    write_word(s, WORD_TYPE, {upper[31:2], kind});
    upper = $urandom;
    write_word(s, WORD_ACTIVE, {upper[31:1], act});
    for (int i = 0; i < 3; i++) write_word(s, 2 + i, c[i]);
    for (int i = 0; i < 9; i++) write_word(s, 5 + i, rt[i]);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += longint'(rt[i * 3 + j]) * longint'(c[j]);
      write_word(s, 14 + i, 32'(-(acc >>> 16)));
    end
    for (int i = 0; i < 3; i++) write_word(s, 17 + i, e[i]);
    write_word(s, WORD_RADIUS, bound);
  endtask

  task automatic random_shape(input int s);
    logic signed [31:0] c[3];
    logic signed [31:0] rt[9];
    logic signed [31:0] e[3];
    logic signed [31:0] bound;
    for (int i = 0; i < 3; i++) begin
      c[i] = $urandom_range(0, 8 * ONE) - 4 * ONE;
      e[i] = ($urandom_range(0, 19) == 0) ? -$urandom_range(1, ONE) :
             $urandom_range(0, 3 * ONE / 2);
    end
    for (int i = 0; i < 9; i++) begin
      if ($urandom_range(0, 1) == 0) rt[i] = (i % 4 == 0) ? ONE : 0;
      else rt[i] = $urandom_range(0, 2 * ONE) - ONE;
    end
    case ($urandom_range(0, 19))
      0: bound = -$urandom_range(1, 4 * ONE);
      1: bound = $urandom_range(0, ONE / 4);
      default: bound = $urandom_range(2 * ONE, 6 * ONE);
    endcase
    load_shape(s, 2'($urandom_range(0, 3)), $urandom_range(0, 4) != 0, c, rt, e, bound);
  endtask

  function automatic in_item_t test_point(logic signed [31:0] x, logic signed [31:0] y,
                                          logic signed [31:0] z, logic fin, logic last);
    in_item_t it;
    it = '0;
    it.cmd = CMD_TEST;
    it.shape_index = 6'($urandom);
    it.word_index = 5'($urandom);
    it.word_value = $urandom;
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    it.point_finite = fin;
    it.last_point = last;
    return it;
  endfunction

  function automatic out_item_t known_result(logic keep, int n, logic done);
    out_item_t r;
    r.keep_point = keep;
    r.kept_count = 20'(n);
    r.cloud_done = done;
    return r;
  endfunction

  function automatic in_item_t random_point();
    int s;
    logic signed [31:0] x, y, z;
    s = slot_of($urandom_range(0, 7));
    case ($urandom_range(0, 19))
      0, 1: begin
        x = $urandom;
        y = $urandom;
        z = $urandom;
      end
      2, 3, 4: begin
        x = $urandom_range(0, 16 * ONE) - 8 * ONE;
        y = $urandom_range(0, 16 * ONE) - 8 * ONE;
        z = $urandom_range(0, 16 * ONE) - 8 * ONE;
      end
      default: begin
        x = tbl_center[s][0] + $urandom_range(0, 2 * ONE) - ONE;
        y = tbl_center[s][1] + $urandom_range(0, 2 * ONE) - ONE;
        z = tbl_center[s][2] + $urandom_range(0, 2 * ONE) - ONE;
      end
    endcase
    return test_point(x, y, z, $urandom_range(0, 11) != 0, $urandom_range(0, 29) == 0);
  endfunction

  task automatic add_row(input in_item_t it, input int new_use, input bit typed,
                         input out_item_t want);
    dir_row_t row;
    row.item = it;
    row.new_use = new_use;
    row.typed = typed;
    row.want = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  initial begin : receiver
    int stall;
    out_item_t exp_r;
    out_ready <= 1'b0;
    forever begin
      if ($urandom_range(0, 59) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %p", out_data));
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.keep_point !== exp_r.keep_point)
          report($sformatf("keep_point %b, expected %b", out_data.keep_point,
                           exp_r.keep_point));
        if (out_data.kept_count !== exp_r.kept_count)
          report($sformatf("kept_count %0d, expected %0d", out_data.kept_count,
                           exp_r.kept_count));
        if (out_data.cloud_done !== exp_r.cloud_done)
          report($sformatf("cloud_done %b, expected %b", out_data.cloud_done,
                           exp_r.cloud_done));
      end
    end
  end

  initial begin : stimulus
    logic signed [31:0] c[3];
    logic signed [31:0] rt[9];
    logic signed [31:0] e[3];
    in_item_t bad;
    int use_list[6];
    int count_list[6];
    int spent;
    kept_tally = '0;
    in_use = 0;
    send_burst = 1'b0;
    for (int s = 0; s < 64; s++) begin
      tbl_active[s] = 1'b0;
      tbl_type[s] = SHAPE_BOX;
      tbl_bound[s] = 0;
      for (int i = 0; i < 3; i++) begin
        tbl_center[s][i] = 0;
        tbl_trans[s][i] = 0;
        tbl_extent[s][i] = 0;
      end
      for (int i = 0; i < 9; i++) tbl_rot[s][i] = 0;
    end
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Shape set for the directed rows: a box, a sphere with a negative radius, a
    // cylinder along z and a shape of the unused fourth type around the origin.
    for (int i = 0; i < 9; i++) rt[i] = (i % 4 == 0) ? ONE : 0;
    c = '{4 * ONE, 0, 0};
    e = '{ONE / 2, ONE / 2, ONE / 2};
    load_shape(0, SHAPE_BOX, 1'b1, c, rt, e, ONE);
    c = '{0, 4 * ONE, 0};
    e = '{-ONE / 2, 0, 0};
    load_shape(1, SHAPE_SPHERE, 1'b1, c, rt, e, ONE);
    c = '{0, 0, 4 * ONE};
    e = '{3 * ONE / 10, 0, 3 * ONE / 5};
    load_shape(2, SHAPE_CYLINDER, 1'b1, c, rt, e, ONE);
    c = '{0, 0, 0};
    e = '{100 * ONE, 100 * ONE, 100 * ONE};
    load_shape(3, 2'd3, 1'b1, c, rt, e, 100 * ONE);

    add_row(test_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1, 0), -1, 1,
            known_result(1, 1, 0));
    add_row(test_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 1, 0), -1, 1,
            known_result(1, 2, 0));
    add_row(test_point(0, 0, 0, 0, 0), -1, 1, known_result(1, 3, 0));
    add_row(test_point(ONE, ONE, ONE, 1, 1), -1, 1, known_result(1, 4, 1));
    add_row(test_point(0, 0, 0, 1, 0), -1, 1, known_result(1, 1, 0));
    bad = '0;
    bad.cmd = CMD_WRITE;
    bad.shape_index = 6'd0;
    bad.word_index = 5'd31;
    bad.word_value = 32'sh7fffffff;
    add_row(bad, -1, 0, '0);
    add_row(test_point(4 * ONE, 0, 0, 1, 0), 4, 0, '0);
    add_row(test_point(4 * ONE + ONE / 2, ONE / 2, -ONE / 2, 1, 0), -1, 0, '0);
    add_row(test_point(4 * ONE + 3 * ONE / 5, 0, 0, 1, 0), -1, 0, '0);
    add_row(test_point(0, 4 * ONE, 0, 1, 0), -1, 0, '0);
    add_row(test_point(0, 4 * ONE + ONE / 2, 0, 1, 0), -1, 0, '0);
    add_row(test_point(0, 0, 4 * ONE, 1, 0), -1, 0, '0);
    add_row(test_point(3 * ONE / 10, 0, 4 * ONE + 3 * ONE / 5, 1, 0), -1, 0, '0);
    add_row(test_point(3 * ONE / 10 + 1, 0, 4 * ONE, 1, 0), -1, 0, '0);
    add_row(test_point(0, 0, 0, 1, 0), -1, 0, '0);
    add_row(test_point(4 * ONE, 0, 0, 0, 0), -1, 0, '0);
    add_row(test_point(4 * ONE, 0, 0, 1, 1), -1, 0, '0);
    add_row(test_point(0, 4 * ONE, 0, 1, 0), 1, 0, '0);
    add_row(test_point(4 * ONE, 0, 0, 1, 1), -1, 0, '0);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].new_use >= 0) set_in_use(dir_rows[k].new_use);
      send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
    end

    use_list = '{64, 127, 1, 0, -1, -1};
    count_list = '{60, 40, 150, 100, 200, 200};
    for (int r = 0; r < 6; r++) begin
      set_in_use(0);
      for (int k = 0; k < 8; k++) begin
        if (r == 0 || $urandom_range(0, 3) == 0) random_shape(slot_of(k));
      end
      set_in_use(use_list[r] >= 0 ? use_list[r] : $urandom_range(2, 12));
      spent = 0;
      while (spent < count_list[r]) begin
        if ($urandom_range(0, 19) == 0) begin
          write_word(slot_of($urandom_range(0, 7)), $urandom_range(0, 31), $urandom);
        end else begin
          send_item(random_point(), 1'b0, '0);
          spent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
